@@ sv/otbm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// otbm_pkg
// Types, opcodes and the slot operation shared by the byte mapper and its cells.
// ----------------------------------------------------------------------------
package otbm_pkg;

    localparam logic [2:0] OPC_ADD    = 3'd0;
    localparam logic [2:0] OPC_AND    = 3'd1;
    localparam logic [2:0] OPC_XOR    = 3'd2;
    localparam logic [2:0] OPC_SHL    = 3'd3;
    localparam logic [2:0] OPC_SHR    = 3'd4;
    localparam logic [2:0] OPC_ASSIGN = 3'd5;

    localparam logic [7:0] SKIP_MASK  = 8'hE0;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] node_index;
        logic [1:0] slot_index;
        logic [2:0] op_code;
        logic [7:0] op_value;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] mapped_byte;
        logic       walk_error;
    } t_out;

    typedef struct packed {
        logic [2:0] opc;
        logic [7:0] val;
    } t_entry;

    typedef struct packed {
        logic       en;
        t_entry     data;
    } t_wr;

    typedef struct packed {
        logic       vld;
        logic [7:0] x;
    } t_link;

    function automatic logic [7:0] otbm_apply(input logic [7:0] x, input t_entry e);
        logic [7:0] r;
        begin
            unique case (e.opc)
                OPC_ADD:    r = x + e.val;
                OPC_AND:    r = x & e.val;
                OPC_XOR:    r = x ^ e.val;
                OPC_SHL:    r = (e.val[7:3] != 5'd0) ? 8'd0 : (x << e.val[2:0]);
                OPC_SHR:    r = (e.val[7:3] != 5'd0) ? 8'd0 : (x >> e.val[2:0]);
                OPC_ASSIGN: r = e.val;
                default:    r = x;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/otbm_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// otbm_cell
// One slot column of the node table; applies its slot to the passing byte.
// ----------------------------------------------------------------------------
module otbm_cell #(
    parameter int NODES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  otbm_pkg::t_wr              i_wr,
    input  logic [$clog2(NODES)-1:0]   i_waddr,
    input  logic [$clog2(NODES)-1:0]   i_raddr,
    input  otbm_pkg::t_link            i_link,
    output otbm_pkg::t_link            o_link,
    output otbm_pkg::t_entry           o_entry
);
    import otbm_pkg::*;

    t_entry     r_mem [NODES];
    t_entry     r_rd;
    logic       r_vld;
    logic [7:0] r_x;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= otbm_apply(i_link.x, r_rd);
    end

    assign o_link  = '{vld: r_vld, x: r_x};
    assign o_entry = r_rd;

endmodule
`default_nettype wire

@@ sv/op_tree_byte_mapper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// op_tree_byte_mapper
// Maps bytes through a binary tree of per-node operation programs.
// ----------------------------------------------------------------------------
// The node table is split over a row of OPS_PER_NODE cells, one per slot, each
// holding its slot for all NODES nodes. A write beat stores one slot entry. A map
// beat walks the tree one node at a time, from node 1: each level visited does
// one table read and one leaf check, then, unless the node is a leaf, the byte
// moves down the row through each cell in turn; the walk ends by loading the
// result register. A byte with its top three bits clear is dropped. After reset
// the table is cleared to zero, during which no beat is taken. A finished result
// waits in the output register while new beats are taken.
module op_tree_byte_mapper #(
    parameter int NODES        = 256,
    parameter int OPS_PER_NODE = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  otbm_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output otbm_pkg::t_out  o_out_data
);
    import otbm_pkg::*;

    localparam int AW  = $clog2(NODES);
    localparam int NXW = ((AW + 1 > 8) ? AW + 1 : 8) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CHECK = 6'b000100,
        S_RUN   = 6'b001000,
        S_OUT   = 6'b010000,
        S_CLEAR = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_node, n_node;
    logic [7:0]       r_byte, n_byte;
    logic [AW-1:0]    r_clr, n_clr;
    t_out             r_res, n_res;
    logic             r_ovld, n_ovld;
    t_out             r_odata, n_odata;

    logic             w_in_fire;
    logic             w_wr_hit;
    logic [AW-1:0]    w_waddr;
    t_entry           w_wdata;
    logic             w_leaf;
    logic [NXW-1:0]   w_next;
    logic             w_out_free;

    t_link            w_link  [OPS_PER_NODE+1];
    t_entry           w_entry [OPS_PER_NODE];
    t_wr              w_wr    [OPS_PER_NODE];
    logic [OPS_PER_NODE-1:0] w_chain_vld;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_wr_hit   = w_in_fire && (i_in_data.func == FUNC_WRITE)
                        && (32'(i_in_data.node_index) < NODES)
                        && (32'(i_in_data.slot_index) < OPS_PER_NODE);

    assign w_waddr = (r_state == S_CLEAR) ? r_clr : AW'(i_in_data.node_index);
    assign w_wdata = (r_state == S_CLEAR) ? t_entry'(0)
                     : t_entry'{opc: i_in_data.op_code, val: i_in_data.op_value};

    assign w_link[0] = '{vld: (r_state == S_CHECK) && !w_leaf, x: r_byte};

    for (genvar g = 0; g < OPS_PER_NODE; g++) begin : g_cell
        assign w_wr[g] = '{en: (r_state == S_CLEAR)
                               || (w_wr_hit && (32'(i_in_data.slot_index) == g)),
                           data: w_wdata};
        assign w_chain_vld[g] = w_link[g+1].vld;

        otbm_cell #(
            .NODES (NODES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr[g]),
            .i_waddr (w_waddr),
            .i_raddr (r_node),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_entry (w_entry[g])
        );
    end

    assign w_leaf     = (w_entry[OPS_PER_NODE-1].opc == OPC_ASSIGN);
    assign w_next     = NXW'({r_node, 1'b0}) + NXW'(w_link[OPS_PER_NODE].x);
    assign w_out_free = !r_ovld || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_node  = r_node;
        n_byte  = r_byte;
        n_clr   = r_clr;
        n_res   = r_res;
        n_ovld  = r_ovld && !i_out_ready;
        n_odata = r_odata;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_fire && (i_in_data.func == FUNC_MAP)
                    && ((i_in_data.data_byte & SKIP_MASK) != 8'd0)) begin
                    n_byte  = i_in_data.data_byte;
                    n_node  = AW'(1);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_leaf) begin
                    n_res   = '{mapped_byte: w_entry[OPS_PER_NODE-1].val, walk_error: 1'b0};
                    n_state = S_OUT;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_link[OPS_PER_NODE].vld) begin
                    if (w_next >= NXW'(NODES)) begin
                        n_res   = '{mapped_byte: 8'd0, walk_error: 1'b1};
                        n_state = S_OUT;
                    end else begin
                        n_node  = w_next[AW-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ovld  = 1'b1;
                    n_odata = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_byte  <= n_byte;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

`ifndef SYNTH
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("beat accepted during table clear");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_chain_vld))
        else $error("more than one byte in the cell row");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.walk_error) |-> (o_out_data.mapped_byte == 8'd0))
        else $error("walk error with nonzero mapped byte");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside output state");
`endif

endmodule
`default_nettype wire
